[src/rssc_pkg.sv]
// Shared widths and status codes for the segment against sphere collision test.
package rssc_pkg;

  localparam int COORD_BITS  = 24;
  localparam int RADIUS_BITS = COORD_BITS - 1;
  localparam int STATUS_BITS = 3;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_COLLISION = 3'd0,
    ST_INSIDE    = 3'd1,
    ST_MISSED    = 3'd2,
    ST_BEHIND    = 3'd3,
    ST_SHORT     = 3'd4
  } status_t;

endpackage

[src/ray_segment_sphere_collision.sv]
// Pipelined segment against sphere collision test with first hit point.
//
// Input channel (in_valid/in_ready): one word per test, a sphere center and
// radius plus segment start and end points in fixed point, all signed but the radius.
// Result channel (out_valid/out_ready): one word per test, a status code
// and, on a collision, the first point where the segment enters the sphere.
//
// One test is taken per cycle while the output is not stalled. The pipeline
// has 86 register stages: eight for products, sums and the discriminant,
// one stage per root bit of the 50-stage square root, three to build the hit
// offset numerator, one per quotient bit of the 24-stage divider, and the
// output register.
//
// The whole pipeline advances together whenever the output register is
// empty or its word is taken; while the receiver stalls a full output,
// every stage holds and in_ready is low, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes out of reset empty and
// ready.
module ray_segment_sphere_collision (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_center_x,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_center_y,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_center_z,
  input  logic [rssc_pkg::RADIUS_BITS-1:0]       in_sphere_radius,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_start_z,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_end_x,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_end_y,
  input  logic signed [rssc_pkg::COORD_BITS-1:0] in_end_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rssc_pkg::STATUS_BITS-1:0]       out_status,
  output logic signed [rssc_pkg::COORD_BITS-1:0] out_hit_x,
  output logic signed [rssc_pkg::COORD_BITS-1:0] out_hit_y,
  output logic signed [rssc_pkg::COORD_BITS-1:0] out_hit_z
);

  localparam int CB  = rssc_pkg::COORD_BITS;
  localparam int RB  = rssc_pkg::RADIUS_BITS;
  localparam int EW  = CB + 1;          // coordinate differences
  localparam int SW  = 2 * EW;          // squares, sums of squares
  localparam int HW  = SW / 2;          // half word for split products
  localparam int QW  = 2 * SW;          // discriminant terms
  localparam int RW  = QW / 2;          // square root bits
  localparam int RMW = RW + 3;          // square root remainder
  localparam int NW  = CB + SW + 2;     // hit offset numerator
  localparam int QB  = CB;              // hit offset quotient bits

  typedef struct packed {
    rssc_pkg::status_t   status;
    logic [SW-1:0]       p;
    logic [SW-1:0]       l2;
    logic [2:0]          dneg;
    logic [2:0][CB-1:0]  dmag;
    logic [2:0][CB-1:0]  s;
  } side_t;

  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: differences ----------------
  logic signed [CB-1:0] cen [3];
  logic signed [CB-1:0] st  [3];
  logic signed [CB-1:0] en  [3];
  assign cen[0] = in_center_x;
  assign cen[1] = in_center_y;
  assign cen[2] = in_center_z;
  assign st[0]  = in_start_x;
  assign st[1]  = in_start_y;
  assign st[2]  = in_start_z;
  assign en[0]  = in_end_x;
  assign en[1]  = in_end_y;
  assign en[2]  = in_end_z;

  logic signed [EW-1:0] e1_nxt [3];
  logic signed [EW-1:0] d1_nxt [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] d1_r [3];
  logic signed [CB-1:0] s1_r [3];
  logic [RB-1:0]        r1_r;
  logic                 v1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = EW'(st[i]) - EW'(cen[i]);
      d1_nxt[i] = EW'(en[i]) - EW'(st[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      e1_r <= e1_nxt;
      d1_r <= d1_nxt;
      s1_r <= st;
      r1_r <= in_sphere_radius;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [SW-1:0] ee2_nxt [3];
  logic signed [SW-1:0] dd2_nxt [3];
  logic signed [SW-1:0] ed2_nxt [3];
  logic [2*RB-1:0]      rr2_nxt;
  logic signed [SW-1:0] ee2_r [3];
  logic signed [SW-1:0] dd2_r [3];
  logic signed [SW-1:0] ed2_r [3];
  logic [2*RB-1:0]      rr2_r;
  logic signed [EW-1:0] d2_r [3];
  logic signed [CB-1:0] s2_r [3];
  logic                 v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ee2_nxt[i] = e1_r[i] * e1_r[i];
      dd2_nxt[i] = d1_r[i] * d1_r[i];
      ed2_nxt[i] = e1_r[i] * d1_r[i];
    end
    rr2_nxt = r1_r * r1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      ee2_r <= ee2_nxt;
      dd2_r <= dd2_nxt;
      ed2_r <= ed2_nxt;
      rr2_r <= rr2_nxt;
      d2_r  <= d1_r;
      s2_r  <= s1_r;
    end
  end

  // ---------------- stage 3: sums ----------------
  logic [SW-1:0]        e2_3_nxt, l2_3_nxt, r2_3_nxt;
  logic signed [SW:0]   dot3_nxt;
  logic [SW-1:0]        e2_3_r, l2_3_r, r2_3_r;
  logic signed [SW:0]   dot3_r;
  logic signed [EW-1:0] d3_r [3];
  logic signed [CB-1:0] s3_r [3];
  logic                 v3_r;

  always_comb begin
    e2_3_nxt = $unsigned(ee2_r[0]) + $unsigned(ee2_r[1]) + $unsigned(ee2_r[2]);
    l2_3_nxt = $unsigned(dd2_r[0]) + $unsigned(dd2_r[1]) + $unsigned(dd2_r[2]);
    r2_3_nxt = SW'(rr2_r);
    dot3_nxt = (SW+1)'(ed2_r[0]) + (SW+1)'(ed2_r[1]) + (SW+1)'(ed2_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      e2_3_r <= e2_3_nxt;
      l2_3_r <= l2_3_nxt;
      r2_3_r <= r2_3_nxt;
      dot3_r <= dot3_nxt;
      d3_r   <= d2_r;
      s3_r   <= s2_r;
    end
  end

  // ---------------- stage 4: flags, magnitudes ----------------
  side_t         side4_nxt, side4_r;
  logic          inside4_nxt, zero4_nxt, behind4_nxt, pgt4_nxt;
  logic          inside4_r, zero4_r, behind4_r, pgt4_r;
  logic [SW-1:0] diff4_nxt, t4_nxt, diff4_r, t4_r;
  logic          v4_r;

  always_comb begin
    side4_nxt        = '0;
    side4_nxt.status = rssc_pkg::ST_COLLISION;
    side4_nxt.p      = dot3_r[SW] ? SW'(-dot3_r) : SW'(dot3_r);
    side4_nxt.l2     = l2_3_r;
    for (int i = 0; i < 3; i++) begin
      side4_nxt.dneg[i] = d3_r[i][EW-1];
      side4_nxt.dmag[i] = d3_r[i][EW-1] ? CB'(-d3_r[i]) : CB'(d3_r[i]);
      side4_nxt.s[i]    = s3_r[i];
    end
    inside4_nxt = e2_3_r < r2_3_r;
    zero4_nxt   = l2_3_r == '0;
    behind4_nxt = !dot3_r[SW] && (dot3_r != '0);
    pgt4_nxt    = side4_nxt.p > l2_3_r;
    diff4_nxt   = e2_3_r - r2_3_r;
    t4_nxt      = side4_nxt.p - l2_3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      side4_r   <= side4_nxt;
      inside4_r <= inside4_nxt;
      zero4_r   <= zero4_nxt;
      behind4_r <= behind4_nxt;
      pgt4_r    <= pgt4_nxt;
      diff4_r   <= diff4_nxt;
      t4_r      <= t4_nxt;
    end
  end

  // ---------------- stage 5: split partial products ----------------
  logic [SW-1:0] ph5_nxt, pm5_nxt, pl5_nxt, lh5_nxt, lm5a_nxt, lm5b_nxt, ll5_nxt;
  logic [SW-1:0] th5_nxt, tm5_nxt, tl5_nxt;
  logic [SW-1:0] ph5_r, pm5_r, pl5_r, lh5_r, lm5a_r, lm5b_r, ll5_r;
  logic [SW-1:0] th5_r, tm5_r, tl5_r;
  side_t         side5_r;
  logic          inside5_r, zero5_r, behind5_r, pgt5_r;
  logic          v5_r;

  always_comb begin
    ph5_nxt  = side4_r.p[SW-1:HW] * side4_r.p[SW-1:HW];
    pm5_nxt  = side4_r.p[SW-1:HW] * side4_r.p[HW-1:0];
    pl5_nxt  = side4_r.p[HW-1:0]  * side4_r.p[HW-1:0];
    lh5_nxt  = side4_r.l2[SW-1:HW] * diff4_r[SW-1:HW];
    lm5a_nxt = side4_r.l2[SW-1:HW] * diff4_r[HW-1:0];
    lm5b_nxt = side4_r.l2[HW-1:0]  * diff4_r[SW-1:HW];
    ll5_nxt  = side4_r.l2[HW-1:0]  * diff4_r[HW-1:0];
    th5_nxt  = t4_r[SW-1:HW] * t4_r[SW-1:HW];
    tm5_nxt  = t4_r[SW-1:HW] * t4_r[HW-1:0];
    tl5_nxt  = t4_r[HW-1:0]  * t4_r[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
    if (adv) begin
      ph5_r     <= ph5_nxt;
      pm5_r     <= pm5_nxt;
      pl5_r     <= pl5_nxt;
      lh5_r     <= lh5_nxt;
      lm5a_r    <= lm5a_nxt;
      lm5b_r    <= lm5b_nxt;
      ll5_r     <= ll5_nxt;
      th5_r     <= th5_nxt;
      tm5_r     <= tm5_nxt;
      tl5_r     <= tl5_nxt;
      side5_r   <= side4_r;
      inside5_r <= inside4_r;
      zero5_r   <= zero4_r;
      behind5_r <= behind4_r;
      pgt5_r    <= pgt4_r;
    end
  end

  // ---------------- stage 6: combine partials ----------------
  logic [QW-1:0] qa6_nxt, qb6_nxt, tt6_nxt, qa6_r, qb6_r, tt6_r;
  side_t         side6_r;
  logic          inside6_r, zero6_r, behind6_r, pgt6_r;
  logic          v6_r;

  always_comb begin
    qa6_nxt = (QW'(ph5_r) << SW) + (QW'(pm5_r) << (HW + 1)) + QW'(pl5_r);
    qb6_nxt = (QW'(lh5_r) << SW) + ((QW'(lm5a_r) + QW'(lm5b_r)) << HW) + QW'(ll5_r);
    tt6_nxt = (QW'(th5_r) << SW) + (QW'(tm5_r) << (HW + 1)) + QW'(tl5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
    if (adv) begin
      qa6_r     <= qa6_nxt;
      qb6_r     <= qb6_nxt;
      tt6_r     <= tt6_nxt;
      side6_r   <= side5_r;
      inside6_r <= inside5_r;
      zero6_r   <= zero5_r;
      behind6_r <= behind5_r;
      pgt6_r    <= pgt5_r;
    end
  end

  // ---------------- stage 7: discriminant ----------------
  logic [QW:0]   dq7;
  logic [QW-1:0] q7_r, tt7_r;
  side_t         side7_r;
  logic          inside7_r, zero7_r, behind7_r, pgt7_r, missed7_r;
  logic          v7_r;

  assign dq7 = {1'b0, qa6_r} - {1'b0, qb6_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
    if (adv) begin
      q7_r      <= dq7[QW-1:0];
      missed7_r <= dq7[QW];
      tt7_r     <= tt6_r;
      side7_r   <= side6_r;
      inside7_r <= inside6_r;
      zero7_r   <= zero6_r;
      behind7_r <= behind6_r;
      pgt7_r    <= pgt6_r;
    end
  end

  // ---------------- stage 8: status ----------------
  side_t         side8_nxt, side8_r;
  logic [QW-1:0] q8_r;
  logic          v8_r;

  always_comb begin
    side8_nxt = side7_r;
    if (inside7_r) begin
      side8_nxt.status = rssc_pkg::ST_INSIDE;
    end else if (zero7_r || missed7_r) begin
      side8_nxt.status = rssc_pkg::ST_MISSED;
    end else if (behind7_r) begin
      side8_nxt.status = rssc_pkg::ST_BEHIND;
    end else if (pgt7_r && (tt7_r > q7_r)) begin
      side8_nxt.status = rssc_pkg::ST_SHORT;
    end else begin
      side8_nxt.status = rssc_pkg::ST_COLLISION;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= v7_r;
    end
    if (adv) begin
      side8_r <= side8_nxt;
      q8_r    <= q7_r;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  logic [RMW-1:0] sq_rem_r  [RW];
  logic [RW-1:0]  sq_root_r [RW];
  logic [QW-1:0]  sq_q_r    [RW];
  side_t          sq_side_r [RW];
  logic [RW-1:0]  sq_vld_r;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RMW-1:0] rem_in, cur, trial, rem_nxt;
    logic [RW-1:0]  root_in, root_nxt;
    logic [QW-1:0]  q_in;
    side_t          side_in;
    logic           vld_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign q_in    = q8_r;
      assign side_in = side8_r;
      assign vld_in  = v8_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign q_in    = sq_q_r[j-1];
      assign side_in = sq_side_r[j-1];
      assign vld_in  = sq_vld_r[j-1];
    end

    assign cur   = {rem_in[RMW-3:0], q_in[QW-1-2*j -: 2]};
    assign trial = RMW'({root_in, 2'b01});

    always_comb begin
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[j] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[j] <= vld_in;
      end
      if (adv) begin
        sq_rem_r[j]  <= rem_nxt;
        sq_root_r[j] <= root_nxt;
        sq_q_r[j]    <= q_in;
        sq_side_r[j] <= side_in;
      end
    end
  end

  // ---------------- N1: distance numerator ----------------
  logic [SW-1:0] num1_nxt, num1_r;
  side_t         side_n1_r;
  logic          vn1_r;

  assign num1_nxt = (SW'(sq_root_r[RW-1]) > sq_side_r[RW-1].p) ? '0 :
                    sq_side_r[RW-1].p - SW'(sq_root_r[RW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn1_r <= 1'b0;
    end else if (adv) begin
      vn1_r <= sq_vld_r[RW-1];
    end
    if (adv) begin
      num1_r    <= num1_nxt;
      side_n1_r <= sq_side_r[RW-1];
    end
  end

  // ---------------- N2: split products per axis ----------------
  logic [CB+HW-1:0] mh2_nxt [3];
  logic [CB+HW-1:0] ml2_nxt [3];
  logic [CB+HW-1:0] mh2_r [3];
  logic [CB+HW-1:0] ml2_r [3];
  side_t            side_n2_r;
  logic             vn2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mh2_nxt[i] = side_n1_r.dmag[i] * num1_r[SW-1:HW];
      ml2_nxt[i] = side_n1_r.dmag[i] * num1_r[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn2_r <= 1'b0;
    end else if (adv) begin
      vn2_r <= vn1_r;
    end
    if (adv) begin
      mh2_r     <= mh2_nxt;
      ml2_r     <= ml2_nxt;
      side_n2_r <= side_n1_r;
    end
  end

  // ---------------- N3: rounding numerator and divisor ----------------
  logic [NW-1:0] numer3_nxt [3];
  logic [NW-1:0] numer3_r [3];
  logic [SW:0]   dvs3_r;
  side_t         side_n3_r;
  logic          vn3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // 2*|d|*num + l2 over 2*l2 rounds half away from zero
      numer3_nxt[i] = (((NW'(mh2_r[i]) << HW) + NW'(ml2_r[i])) << 1)
                      + NW'(side_n2_r.l2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn3_r <= 1'b0;
    end else if (adv) begin
      vn3_r <= vn2_r;
    end
    if (adv) begin
      numer3_r  <= numer3_nxt;
      dvs3_r    <= {side_n2_r.l2, 1'b0};
      side_n3_r <= side_n2_r;
    end
  end

  // ---------------- divider, one quotient bit per stage ----------------
  logic [NW-1:0] dv_rem_r [QB][3];
  logic [QB-1:0] dv_quo_r [QB][3];
  logic [SW:0]   dv_dvs_r [QB];
  side_t         dv_side_r [QB];
  logic [QB-1:0] dv_vld_r;

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [NW-1:0] rem_in  [3];
    logic [QB-1:0] quo_in  [3];
    logic [NW-1:0] rem_nxt [3];
    logic [QB-1:0] quo_nxt [3];
    logic [NW-1:0] cmpv;
    logic [SW:0]   dvs_in;
    side_t         side_in;
    logic          vld_in;

    if (k == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = numer3_r[i];
        assign quo_in[i] = '0;
      end
      assign dvs_in  = dvs3_r;
      assign side_in = side_n3_r;
      assign vld_in  = vn3_r;
    end else begin : g_next
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = dv_rem_r[k-1][i];
        assign quo_in[i] = dv_quo_r[k-1][i];
      end
      assign dvs_in  = dv_dvs_r[k-1];
      assign side_in = dv_side_r[k-1];
      assign vld_in  = dv_vld_r[k-1];
    end

    assign cmpv = NW'(dvs_in) << (QB - 1 - k);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= cmpv) begin
          rem_nxt[i] = rem_in[i] - cmpv;
          quo_nxt[i] = {quo_in[i][QB-2:0], 1'b1};
        end else begin
          rem_nxt[i] = rem_in[i];
          quo_nxt[i] = {quo_in[i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k] <= vld_in;
      end
      if (adv) begin
        dv_rem_r[k]  <= rem_nxt;
        dv_quo_r[k]  <= quo_nxt;
        dv_dvs_r[k]  <= dvs_in;
        dv_side_r[k] <= side_in;
      end
    end
  end

  // ---------------- output: hit point, saturate, register ----------------
  side_t                 fin;
  logic signed [CB+1:0]  hsum [3];
  logic signed [CB+1:0]  offs [3];
  logic signed [CB-1:0]  hit_nxt [3];
  logic signed [CB-1:0]  hit_r [3];
  logic [rssc_pkg::STATUS_BITS-1:0] out_status_r;

  assign fin = dv_side_r[QB-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      offs[i] = $signed({2'b00, dv_quo_r[QB-1][i]});
      hsum[i] = (CB+2)'($signed(fin.s[i])) + (fin.dneg[i] ? -offs[i] : offs[i]);
      if (fin.status != rssc_pkg::ST_COLLISION) begin
        hit_nxt[i] = '0;
      end else if (hsum[i][CB+1:CB-1] == 3'b000 || hsum[i][CB+1:CB-1] == 3'b111) begin
        hit_nxt[i] = hsum[i][CB-1:0];
      end else if (hsum[i][CB+1]) begin
        hit_nxt[i] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        hit_nxt[i] = {1'b0, {(CB-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[QB-1];
    end
    if (adv) begin
      out_status_r <= fin.status;
      hit_r        <= hit_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_hit_x  = hit_r[0];
  assign out_hit_y  = hit_r[1];
  assign out_hit_z  = hit_r[2];

`ifndef SYNTHESIS
  // A root must leave a remainder no larger than twice itself.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r[RW-1] |-> (sq_rem_r[RW-1] <= RMW'({sq_root_r[RW-1], 1'b0})))
    else $error("square root remainder out of range");

  // On a collision every axis quotient leaves a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[QB-1] && dv_side_r[QB-1].status == rssc_pkg::ST_COLLISION) |->
      (dv_rem_r[QB-1][0] < NW'(dv_dvs_r[QB-1]) &&
       dv_rem_r[QB-1][1] < NW'(dv_dvs_r[QB-1]) &&
       dv_rem_r[QB-1][2] < NW'(dv_dvs_r[QB-1])))
    else $error("divider remainder out of range");

  // A held output freezes the whole pipeline.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> ($stable(sq_vld_r) && $stable(dv_vld_r) && $stable(v8_r)))
    else $error("pipeline moved during stall");

  // Hit fields stay zero unless the word reports a collision.
  a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rssc_pkg::ST_COLLISION) |->
      (out_hit_x == '0 && out_hit_y == '0 && out_hit_z == '0))
    else $error("hit point without collision");
`endif

endmodule
